/* rtl/csba_pkg.sv */
`default_nettype none

package csba_pkg;

	localparam int NODES = 4;
	localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int DRAW_NODES = 4;
	localparam int MASK_NODES = (NODES < 4) ? NODES : 4;
	localparam int CFG_REGS = 4;
	localparam int CFG_IDX_W = 2;
	localparam int TT_W = 4;
	localparam int BO_W = 3;
	localparam int CNT_W = 16;
	localparam logic [TT_W-1:0] TT_RESET = TT_W'(1);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		OUTCOME_NONE = 2'd0,
		OUTCOME_START = 2'd1,
		OUTCOME_COLLIDE = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [31:0] defer_draws;
		logic [31:0] collision_draws;
	} req_t;

	typedef struct packed {
		logic [1:0] slot_outcome;
		logic channel_busy;
		logic [1:0] owner_node;
		logic [1:0] winner_node;
		logic [3:0] collided_mask;
		logic [3:0] deferred_mask;
		logic [3:0] waiting_mask;
		logic [15:0] total_transmissions;
		logic [15:0] total_collisions;
		logic [63:0] wait_counts;
	} rsp_t;

	typedef struct packed {
		logic ready;
		logic active;
	} lane_stat_t;

	typedef struct packed {
		logic defer;
		logic start;
		logic collide;
	} lane_cmd_t;

	typedef struct packed {
		outcome_t outcome;
		logic busy;
		logic [NODE_W-1:0] owner;
		logic [NODE_W-1:0] winner;
	} slot_sum_t;

	// Remainder by three through a reciprocal multiply, exact for all byte values.
	function automatic logic [1:0] mod3(input logic [7:0] x);
		logic [16:0] p;
		logic [7:0] q;
		logic [7:0] r;
		p = {9'd0, x} * 17'd171;
		q = p[16:9];
		r = x - ((q << 1) + q);
		return r[1:0];
	endfunction

	// Remainder by six through a reciprocal multiply, exact for all byte values.
	function automatic logic [2:0] mod6(input logic [7:0] x);
		logic [16:0] p;
		logic [7:0] q;
		logic [7:0] r;
		p = {9'd0, x} * 17'd171;
		q = {1'b0, p[16:10]};
		r = x - ((q << 2) + (q << 1));
		return r[2:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/csba_ifs.sv */
`default_nettype none

interface csba_req_if;
	import csba_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface csba_rsp_if;
	import csba_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/csba_lane.sv */
`default_nettype none

module csba_lane (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire logic cfg_we,
	input wire logic [csba_pkg::TT_W-1:0] cfg_data,
	input wire logic [7:0] defer_draw,
	input wire logic [7:0] coll_draw,
	input wire csba_pkg::lane_cmd_t cmd,
	output csba_pkg::lane_stat_t stat,
	output logic [csba_pkg::CNT_W-1:0] wait_next
);
	import csba_pkg::*;

	logic [TT_W-1:0] tt_q;
	logic [BO_W-1:0] backoff_q;
	logic [BO_W-1:0] backoff_n;
	logic [TT_W-1:0] remaining_q;
	logic [TT_W-1:0] rem_set;
	logic [TT_W-1:0] remaining_n;
	logic [CNT_W-1:0] wait_q;
	logic bo_zero;

	always_comb begin
		bo_zero = (backoff_q == '0);
		stat.ready = bo_zero;
		stat.active = (remaining_q != '0);

		if (cmd.defer) begin
			backoff_n = BO_W'(mod3(defer_draw));
		end else if (cmd.collide) begin
			backoff_n = mod6(coll_draw);
		end else if (!bo_zero) begin
			backoff_n = backoff_q - BO_W'(1);
		end else begin
			backoff_n = backoff_q;
		end

		if (cmd.start) begin
			rem_set = tt_q;
		end else if (cmd.collide) begin
			rem_set = '0;
		end else begin
			rem_set = remaining_q;
		end
		remaining_n = (rem_set != '0) ? rem_set - TT_W'(1) : rem_set;

		if ((!bo_zero || cmd.collide) && wait_q != CNT_MAX) begin
			wait_next = wait_q + CNT_W'(1);
		end else begin
			wait_next = wait_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tt_q <= TT_RESET;
			backoff_q <= '0;
			remaining_q <= '0;
			wait_q <= '0;
		end else begin
			if (cfg_we) begin
				tt_q <= cfg_data;
			end
			if (step) begin
				backoff_q <= backoff_n;
				remaining_q <= remaining_n;
				wait_q <= wait_next;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/csba_merge.sv */
`default_nettype none

module csba_merge (
	input wire csba_pkg::lane_stat_t stat [csba_pkg::NODES],
	output csba_pkg::lane_cmd_t cmd [csba_pkg::NODES],
	output csba_pkg::slot_sum_t sum
);
	import csba_pkg::*;

	logic [NODES-1:0] active_vec;
	logic [NODES-1:0] ready_vec;
	logic any_ready;
	logic one_ready;

	always_comb begin
		for (int i = 0; i < NODES; i++) begin
			active_vec[i] = stat[i].active;
			ready_vec[i] = stat[i].ready;
		end

		sum.busy = |active_vec;
		sum.owner = '0;
		for (int i = NODES - 1; i >= 0; i--) begin
			if (active_vec[i]) begin
				sum.owner = NODE_W'(i);
			end
		end

		sum.winner = '0;
		for (int i = 0; i < NODES; i++) begin
			if (ready_vec[i]) begin
				sum.winner = NODE_W'(i);
			end
		end

		any_ready = |ready_vec;
		one_ready = any_ready && ((ready_vec & (ready_vec - NODES'(1))) == '0);

		if (sum.busy || !any_ready) begin
			sum.outcome = OUTCOME_NONE;
		end else if (one_ready) begin
			sum.outcome = OUTCOME_START;
		end else begin
			sum.outcome = OUTCOME_COLLIDE;
		end

		for (int i = 0; i < NODES; i++) begin
			cmd[i].defer = sum.busy && ready_vec[i] && (sum.owner != NODE_W'(i));
			cmd[i].start = (sum.outcome == OUTCOME_START) && ready_vec[i];
			cmd[i].collide = (sum.outcome == OUTCOME_COLLIDE) && ready_vec[i];
		end
	end

endmodule

`default_nettype wire

/* rtl/csba_rsp_buf.sv */
`default_nettype none

module csba_rsp_buf (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire csba_pkg::rsp_t push_data,
	output logic can_push,
	csba_rsp_if.source result
);
	import csba_pkg::*;

	logic head_v_q;
	logic skid_v_q;
	rsp_t head_q;
	rsp_t skid_q;
	logic pop;

	assign pop = head_v_q && result.ready;
	assign can_push = !skid_v_q;
	assign result.valid = head_v_q;
	assign result.data = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!head_v_q || pop) begin
			head_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!head_v_q || pop) begin
			head_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

/* rtl/csma_slot_backoff_arbiter.sv */
// Slotted carrier-sense arbiter with random backoff for four contending nodes.
// Each request on the draws channel runs one time slot and carries two packed
// words of random bytes, byte i belonging to node i: one for deferral on a busy
// channel and one for backoff after a collision. Each slot yields exactly one
// request on the result channel with the slot outcome, busy and winning node,
// the collided, deferred and waiting masks, and the saturating statistics as
// they stand after the slot.
// Transmit times are set through the write port; index i holds node i. The user
// makes writes only while no slot is in flight; the block does not enforce it.
// A request is taken every cycle while draws.ready is high; the node lanes
// update their counters on acceptance and the result goes to the result buffer.
// The result side has a two-entry buffer, so the draws channel keeps accepting
// while one result waits; with two results waiting, draws.ready falls until
// the receiver takes one.
// Reset clears all backoff, remaining and statistics counters, sets every
// transmit time to one and empties the result buffer.
`default_nettype none

module csma_slot_backoff_arbiter (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [csba_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [csba_pkg::TT_W-1:0] cfg_data,
	csba_req_if.sink draws,
	csba_rsp_if.source result
);
	import csba_pkg::*;

	lane_stat_t stat [NODES];
	lane_cmd_t cmd [NODES];
	logic [CNT_W-1:0] wait_next [NODES];
	slot_sum_t sum;
	logic step;
	logic can_push;
	logic [CNT_W-1:0] tx_cnt_q;
	logic [CNT_W-1:0] coll_cnt_q;
	logic [CNT_W-1:0] tx_next;
	logic [CNT_W-1:0] coll_next;
	logic [NODES-1:0] start_mask;
	logic [NODES-1:0] collide_mask;
	rsp_t rsp;

	assign draws.ready = can_push;
	assign step = draws.valid && can_push;

	for (genvar i = 0; i < NODES; i++) begin : g_lane
		logic we;
		logic [7:0] d_byte;
		logic [7:0] c_byte;

		if (i < CFG_REGS) begin : g_cfg
			assign we = cfg_wr_en && (cfg_index == CFG_IDX_W'(i));
		end else begin : g_nocfg
			assign we = 1'b0;
		end

		if (i < DRAW_NODES) begin : g_draw
			assign d_byte = draws.data.defer_draws[8*i +: 8];
			assign c_byte = draws.data.collision_draws[8*i +: 8];
		end else begin : g_nodraw
			assign d_byte = 8'd0;
			assign c_byte = 8'd0;
		end

		csba_lane u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.step(step),
			.cfg_we(we),
			.cfg_data(cfg_data),
			.defer_draw(d_byte),
			.coll_draw(c_byte),
			.cmd(cmd[i]),
			.stat(stat[i]),
			.wait_next(wait_next[i])
		);
	end

	csba_merge u_merge (
		.stat(stat),
		.cmd(cmd),
		.sum(sum)
	);

	always_comb begin
		tx_next = tx_cnt_q;
		coll_next = coll_cnt_q;
		if (sum.outcome == OUTCOME_START && tx_cnt_q != CNT_MAX) begin
			tx_next = tx_cnt_q + CNT_W'(1);
		end
		if (sum.outcome == OUTCOME_COLLIDE && coll_cnt_q != CNT_MAX) begin
			coll_next = coll_cnt_q + CNT_W'(1);
		end

		for (int i = 0; i < NODES; i++) begin
			start_mask[i] = cmd[i].start;
			collide_mask[i] = cmd[i].collide;
		end

		rsp = '0;
		rsp.slot_outcome = sum.outcome;
		rsp.channel_busy = sum.busy;
		rsp.owner_node = sum.busy ? 2'(sum.owner) : 2'd0;
		rsp.winner_node = (sum.outcome == OUTCOME_START) ? 2'(sum.winner) : 2'd0;
		for (int i = 0; i < MASK_NODES; i++) begin
			rsp.collided_mask[i] = cmd[i].collide;
			rsp.deferred_mask[i] = cmd[i].defer;
			rsp.waiting_mask[i] = !stat[i].ready;
			rsp.wait_counts[CNT_W*i +: CNT_W] = wait_next[i];
		end
		rsp.total_transmissions = tx_next;
		rsp.total_collisions = coll_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_cnt_q <= '0;
			coll_cnt_q <= '0;
		end else if (step) begin
			tx_cnt_q <= tx_next;
			coll_cnt_q <= coll_next;
		end
	end

	csba_rsp_buf u_buf (
		.clk(clk),
		.arst_n(arst_n),
		.push(step),
		.push_data(rsp),
		.can_push(can_push),
		.result(result)
	);

	a_one_start: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(start_mask))
		else $error("more than one node started in a slot");

	a_busy_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		sum.busy |-> (start_mask == '0 && collide_mask == '0))
		else $error("start or collision on a busy channel");

	a_collide_two: assert property (@(posedge clk) disable iff (!arst_n)
		(sum.outcome == OUTCOME_COLLIDE) |-> ($countones(collide_mask) >= 2))
		else $error("collision with fewer than two nodes");

	a_coll_count: assert property (@(posedge clk) disable iff (!arst_n)
		(step && sum.outcome == OUTCOME_COLLIDE) |=> (coll_cnt_q != '0))
		else $error("collision count did not advance");

endmodule

`default_nettype wire

/* dv/csba_slot_checker.sv */
`timescale 1ns / 1ps

module csba_slot_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [csba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [csba_pkg::TT_W-1:0]      cfg_data,
	csba_req_if                                 draws,
	csba_rsp_if                                 result,
	output int                                  mismatches,
	output int                                  outstanding
);
	import csba_pkg::*;

	logic [TT_W-1:0]  tx_time       [NODES];
	logic [BO_W-1:0]  backoff_left  [NODES];
	logic [TT_W-1:0]  airtime_left  [NODES];
	logic [CNT_W-1:0] wait_tally    [NODES];
	logic [CNT_W-1:0] start_tally;
	logic [CNT_W-1:0] collide_tally;
	rsp_t             slot_results[$];
	int               errs;

	function automatic logic [CNT_W-1:0] bump16(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [7:0] node_byte(input logic [31:0] packed_draws, input int n);
		if (n >= DRAW_NODES)
			return 8'd0;
		return packed_draws[8*n +: 8];
	endfunction

	// Advances the node lanes by one slot and returns what the block must report.
	function automatic rsp_t run_slot(input req_t r);
		rsp_t             o;
		logic             busy;
		int               busy_idx;
		logic             contend [NODES];
		int               contenders;
		int               win_idx;
		logic [BO_W-1:0]  draw_bo;
		o = '0;
		busy = 1'b0;
		busy_idx = 0;
		contenders = 0;
		win_idx = 0;
		for (int n = NODES - 1; n >= 0; n--) begin
			if (airtime_left[n] != '0) begin
				busy = 1'b1;
				busy_idx = n;
			end
		end
		for (int n = 0; n < NODES; n++) begin
			contend[n] = 1'b0;
			if (backoff_left[n] == '0) begin
				if (busy) begin
					if (n != busy_idx) begin
						draw_bo = BO_W'(node_byte(r.defer_draws, n) % 3 + 1);
						backoff_left[n] = draw_bo;
						if (n < MASK_NODES)
							o.deferred_mask[n] = 1'b1;
					end
				end else begin
					contend[n] = 1'b1;
					contenders++;
					win_idx = n;
				end
			end else begin
				if (n < MASK_NODES)
					o.waiting_mask[n] = 1'b1;
				wait_tally[n] = bump16(wait_tally[n]);
			end
		end
		if (contenders == 1) begin
			o.slot_outcome = OUTCOME_START;
			start_tally = bump16(start_tally);
			airtime_left[win_idx] = tx_time[win_idx];
			backoff_left[win_idx] = '0;
		end else if (contenders > 1) begin
			o.slot_outcome = OUTCOME_COLLIDE;
			collide_tally = bump16(collide_tally);
			for (int n = 0; n < NODES; n++) begin
				if (contend[n]) begin
					draw_bo = BO_W'(node_byte(r.collision_draws, n) % 6 + 1);
					backoff_left[n] = draw_bo;
					airtime_left[n] = '0;
					wait_tally[n] = bump16(wait_tally[n]);
					if (n < MASK_NODES)
						o.collided_mask[n] = 1'b1;
				end
			end
		end else begin
			o.slot_outcome = OUTCOME_NONE;
		end
		for (int n = 0; n < NODES; n++) begin
			if (backoff_left[n] != '0)
				backoff_left[n] = backoff_left[n] - 1'b1;
			if (airtime_left[n] != '0)
				airtime_left[n] = airtime_left[n] - 1'b1;
			if (n < MASK_NODES)
				o.wait_counts[16*n +: 16] = wait_tally[n];
		end
		o.channel_busy = busy;
		o.owner_node = busy ? 2'(busy_idx) : 2'd0;
		o.winner_node = (contenders == 1) ? 2'(win_idx) : 2'd0;
		o.total_transmissions = start_tally;
		o.total_collisions = collide_tally;
		return o;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			errs++;
			if (errs <= 10)
				$display("mismatch %s: expected %h, got %h", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			for (int n = 0; n < NODES; n++) begin
				tx_time[n] = TT_RESET;
				backoff_left[n] = '0;
				airtime_left[n] = '0;
				wait_tally[n] = '0;
			end
			start_tally = '0;
			collide_tally = '0;
			slot_results.delete();
			errs = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_wr_en && cfg_index < NODES)
				tx_time[cfg_index] = cfg_data;
			if (result.valid && result.ready) begin
				got = result.data;
				if (slot_results.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("result request with nothing expected: %h", got);
				end else begin
					want = slot_results.pop_front();
					check_field("slot_outcome", 64'(want.slot_outcome), 64'(got.slot_outcome));
					check_field("channel_busy", 64'(want.channel_busy), 64'(got.channel_busy));
					check_field("owner_node", 64'(want.owner_node), 64'(got.owner_node));
					check_field("winner_node", 64'(want.winner_node), 64'(got.winner_node));
					check_field("collided_mask", 64'(want.collided_mask),
						64'(got.collided_mask));
					check_field("deferred_mask", 64'(want.deferred_mask),
						64'(got.deferred_mask));
					check_field("waiting_mask", 64'(want.waiting_mask), 64'(got.waiting_mask));
					check_field("total_transmissions", 64'(want.total_transmissions),
						64'(got.total_transmissions));
					check_field("total_collisions", 64'(want.total_collisions),
						64'(got.total_collisions));
					check_field("wait_counts", want.wait_counts, got.wait_counts);
				end
			end
			if (draws.valid && draws.ready)
				slot_results.insert(slot_results.size(), run_slot(draws.data));
			mismatches <= errs;
			outstanding <= slot_results.size();
		end
	end

endmodule

/* dv/tb_csma_slot_backoff_arbiter.sv */
`timescale 1ns / 1ps

module tb_csma_slot_backoff_arbiter;
	import csba_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_PER_PHASE = 132;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TT_W-1:0]      cfg_data;
	int                   mismatches;
	int                   outstanding;
	int                   sender_idle;
	int                   recv_stall;
	int                   hold_left;
	int                   cycles;

	csba_req_if draws_if();
	csba_rsp_if result_if();

	csma_slot_backoff_arbiter u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.draws(draws_if),
		.result(result_if)
	);

	csba_slot_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.draws(draws_if),
		.result(result_if),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("** csma_slot_backoff_arbiter: FAILED **");
				$finish;
			end
		end
	end

	// The receiver stalls at random, or for a whole stretch while hold_left counts down.
	initial begin
		result_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(0, 99) >= recv_stall);
			end
		end
	end

	task automatic send_slot(input logic [31:0] defer_word, input logic [31:0] coll_word);
		req_t r;
		r.defer_draws = defer_word;
		r.collision_draws = coll_word;
		while ($urandom_range(0, 99) < sender_idle) begin
			draws_if.valid <= 1'b0;
			@(posedge clk);
		end
		draws_if.valid <= 1'b1;
		draws_if.data <= r;
		@(posedge clk);
		while (!draws_if.ready)
			@(posedge clk);
	endtask

	task automatic settle();
		draws_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_airtimes(input logic [TT_W-1:0] t0, input logic [TT_W-1:0] t1,
		input logic [TT_W-1:0] t2, input logic [TT_W-1:0] t3);
		logic [TT_W-1:0] vals [4];
		vals = '{t0, t1, t2, t3};
		for (int n = 0; n < CFG_REGS; n++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_IDX_W'(n);
			cfg_data <= vals[n];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_draws();
		logic [31:0] w;
		w = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			for (int b = 0; b < 4; b++)
				w[8*b +: 8] = 8'($urandom_range(0, 7));
		end
		return w;
	endfunction

	initial begin
		draws_if.valid = 1'b0;
		draws_if.data = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		sender_idle = 0;
		recv_stall = 0;
		hold_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All nodes ready at once, then collisions with extreme and small draws.
		send_slot(32'h0000_0000, 32'h0000_0000);
		send_slot(32'h0000_0000, 32'hFFFF_FFFF);
		send_slot(32'hFFFF_FFFF, 32'h0504_0302);
		send_slot(32'hFEFD_FCFB, 32'h0001_0203);
		send_slot(32'h0102_0300, 32'hFF00_FF00);
		send_slot(32'h8040_2010, 32'h0805_0201);
		send_slot(32'hFFFF_FFFF, 32'h0000_0000);
		send_slot(32'h0000_0000, 32'h0500_0000);
		send_slot(32'h5555_AAAA, 32'hAAAA_5555);
		settle();
		// Long transmissions keep the channel busy so that others defer.
		set_airtimes(4'd15, 4'd15, 4'd15, 4'd15);
		send_slot(32'h0000_0000, 32'h0505_0500);
		for (int k = 0; k < 8; k++)
			send_slot(32'hFFFF_FFFF - k, 32'h0505_0500);
		settle();
		// A transmit time of zero never occupies the channel.
		set_airtimes(4'd0, 4'd0, 4'd0, 4'd0);
		for (int k = 0; k < 6; k++)
			send_slot(32'h0201_0002, 32'h0503_0100 + k);
		settle();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: set_airtimes(4'd15, 4'd1, 4'd15, 4'd1);
				1: set_airtimes(4'd1, 4'd1, 4'd1, 4'd1);
				2: set_airtimes(4'd0, 4'd15, 4'd7, 4'd3);
				default: set_airtimes(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
			endcase
			case (p)
				0: begin sender_idle = 0;  recv_stall = 0;  end
				1: begin sender_idle = 66; recv_stall = 0;  end
				2: begin sender_idle = 0;  recv_stall = 66; end
				default: begin sender_idle = 24; recv_stall = 24; end
			endcase
			for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
				if (p == 0 && k == 40)
					hold_left = 300;
				if (p == 3 && k == 70)
					settle();
				send_slot(pick_draws(), pick_draws());
			end
			settle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("** csma_slot_backoff_arbiter: PASSED **");
		end else begin
			$display("** csma_slot_backoff_arbiter: FAILED **");
		end
		$finish;
	end

endmodule
